### design/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Shared types and constants for the windowed momentum signal block.
// ----------------------------------------------------------------------------
package wms_pkg;

    localparam int SYM_IN_W  = 4;
    localparam int PRICE_W   = 32;
    localparam int THR_W     = 24;

    localparam logic [THR_W-1:0] THRESH_RESET = 24'd33554;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic [SYM_IN_W-1:0] symbol_index;
        logic [PRICE_W-1:0]  price;
    } t_in;

    typedef struct packed {
        logic [SYM_IN_W-1:0] signal_symbol;
        logic                side;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_META,
        ST_SUM,
        ST_DRAIN,
        ST_MUL,
        ST_CMP
    } t_state;

endpackage

### design/wms_ram.sv
// ----------------------------------------------------------------------------
// wms_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module wms_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/wms_ctrl.sv
// ----------------------------------------------------------------------------
// wms_ctrl
// Sequencer and datapath: ring update, windowed sums, threshold compare,
// result register. Drives the window and per-symbol state RAMs.
// ----------------------------------------------------------------------------
module wms_ctrl #(
    parameter int SYMBOLS    = 16,
    parameter int WINDOW_LEN = 20,
    parameter int MIN_FILL   = 10,
    parameter int AVG_LEN    = 5,
    localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1,
    localparam int ADDR_W = $clog2(SYMBOLS * WINDOW_LEN),
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1),
    localparam int SLOT_W = $clog2(WINDOW_LEN),
    localparam int META_W = CNT_W + SLOT_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [wms_pkg::THR_W-1:0]     i_thr,
    input  logic                          i_in_valid,
    input  wms_pkg::t_in                  i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output wms_pkg::t_out                 o_out_data,
    input  logic                          i_out_stall,
    output logic                          o_win_we,
    output logic [ADDR_W-1:0]             o_win_addr,
    output logic [wms_pkg::PRICE_W-1:0]   o_win_wdata,
    input  logic [wms_pkg::PRICE_W-1:0]   i_win_rdata,
    output logic                          o_meta_we,
    output logic [SYM_W-1:0]              o_meta_addr,
    output logic [META_W-1:0]             o_meta_wdata,
    input  logic [META_W-1:0]             i_meta_rdata
);

    localparam int LEN_W  = $clog2(AVG_LEN + 1);
    localparam int ISS_W  = LEN_W + 1;
    localparam int SUM_W  = wms_pkg::PRICE_W + $clog2(AVG_LEN + 1);
    localparam int PROD_W = SUM_W + wms_pkg::THR_W;
    localparam int EXT_W  = SYM_W + wms_pkg::SYM_IN_W;

    wms_pkg::t_state r_state, n_state;

    logic [SYM_W-1:0]           r_clr;
    logic [SYM_W-1:0]           r_sym;
    logic [wms_pkg::SYM_IN_W-1:0] r_sym_out;
    logic [ADDR_W-1:0]          r_base;
    logic [wms_pkg::PRICE_W-1:0] r_price;
    logic [SLOT_W-1:0]          r_slot;
    logic [SLOT_W-1:0]          r_rec_slot;
    logic [LEN_W-1:0]           r_len;
    logic [ISS_W-1:0]           r_issue;
    logic                       r_rd_vld;
    logic                       r_rd_rec;
    logic [SUM_W-1:0]           r_acc_old;
    logic [SUM_W-1:0]           r_acc_rec;
    logic [PROD_W-1:0]          r_prod;
    logic [SUM_W-1:0]           r_diff;
    logic                       r_rising;
    logic                       r_nz;
    logic                       r_out_vld;
    wms_pkg::t_out              r_out;

    logic [EXT_W-1:0]  sym_ext;
    logic              sym_ok;
    logic              in_acc;
    logic [CNT_W-1:0]  m_cnt;
    logic [SLOT_W-1:0] m_old;
    logic [CNT_W:0]    m_sum;
    logic [SLOT_W-1:0] wr_slot;
    logic [CNT_W-1:0]  nw_cnt;
    logic [SLOT_W-1:0] nw_old;
    logic [LEN_W-1:0]  nw_len;
    logic [CNT_W:0]    rec_sum;
    logic [SLOT_W-1:0] rec_slot;
    logic              fill_ok;
    logic              last_old;
    logic              last_iss;
    logic              hit;
    logic              out_take;
    logic              out_load;

    assign sym_ext = EXT_W'(i_in_data.symbol_index);
    assign sym_ok  = int'(sym_ext) < SYMBOLS;
    assign in_acc  = i_in_valid && (r_state == wms_pkg::ST_IDLE);

    // ring update from the stored fill count and oldest slot
    always_comb begin
        m_cnt = i_meta_rdata[META_W-1:SLOT_W];
        m_old = i_meta_rdata[SLOT_W-1:0];
        m_sum = (CNT_W+1)'(m_old) + (CNT_W+1)'(m_cnt);
        if (int'(m_cnt) < WINDOW_LEN) begin
            wr_slot = (int'(m_sum) >= WINDOW_LEN) ?
                      SLOT_W'(m_sum - (CNT_W+1)'(WINDOW_LEN)) : SLOT_W'(m_sum);
            nw_cnt  = m_cnt + 1'b1;
            nw_old  = m_old;
        end else begin
            wr_slot = m_old;
            nw_cnt  = m_cnt;
            nw_old  = (m_old == SLOT_W'(WINDOW_LEN - 1)) ? '0 : m_old + 1'b1;
        end
        nw_len   = (AVG_LEN < int'(nw_cnt)) ? LEN_W'(AVG_LEN) : LEN_W'(nw_cnt);
        rec_sum  = (CNT_W+1)'(nw_old) + (CNT_W+1)'(nw_cnt) - (CNT_W+1)'(nw_len);
        rec_slot = (int'(rec_sum) >= WINDOW_LEN) ?
                   SLOT_W'(rec_sum - (CNT_W+1)'(WINDOW_LEN)) : SLOT_W'(rec_sum);
        fill_ok  = int'(nw_cnt) >= MIN_FILL;
    end

    assign last_old = r_issue == (ISS_W'(r_len) - 1'b1);
    assign last_iss = r_issue == ({r_len, 1'b0} - 1'b1);
    assign hit      = r_nz && ({r_diff, wms_pkg::THR_W'(0)} > r_prod);
    assign out_take = r_out_vld && !i_out_stall;
    assign out_load = (r_state == wms_pkg::ST_CMP) && hit && (!r_out_vld || !i_out_stall);

    always_comb begin
        n_state      = r_state;
        o_win_we     = 1'b0;
        o_win_addr   = r_base + ADDR_W'(r_slot);
        o_win_wdata  = r_price;
        o_meta_we    = 1'b0;
        o_meta_addr  = sym_ext[SYM_W-1:0];
        o_meta_wdata = {nw_cnt, nw_old};
        case (r_state)
            wms_pkg::ST_CLEAR: begin
                o_meta_we    = 1'b1;
                o_meta_addr  = r_clr;
                o_meta_wdata = '0;
                if (r_clr == SYM_W'(SYMBOLS - 1)) begin
                    n_state = wms_pkg::ST_IDLE;
                end
            end
            wms_pkg::ST_IDLE: begin
                if (in_acc && sym_ok) begin
                    n_state = wms_pkg::ST_META;
                end
            end
            wms_pkg::ST_META: begin
                o_win_we    = 1'b1;
                o_win_addr  = r_base + ADDR_W'(wr_slot);
                o_meta_we   = 1'b1;
                o_meta_addr = r_sym;
                n_state     = fill_ok ? wms_pkg::ST_SUM : wms_pkg::ST_IDLE;
            end
            wms_pkg::ST_SUM: begin
                if (last_iss) begin
                    n_state = wms_pkg::ST_DRAIN;
                end
            end
            wms_pkg::ST_DRAIN: begin
                n_state = wms_pkg::ST_MUL;
            end
            wms_pkg::ST_MUL: begin
                n_state = wms_pkg::ST_CMP;
            end
            wms_pkg::ST_CMP: begin
                if (!hit || out_load) begin
                    n_state = wms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wms_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == wms_pkg::ST_SUM);
            if (r_state == wms_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sym     <= sym_ext[SYM_W-1:0];
            r_sym_out <= i_in_data.symbol_index;
            r_price   <= i_in_data.price;
            r_base    <= ADDR_W'(int'(sym_ext[SYM_W-1:0]) * WINDOW_LEN);
        end
        if (r_state == wms_pkg::ST_META) begin
            r_slot     <= nw_old;
            r_rec_slot <= rec_slot;
            r_len      <= nw_len;
            r_issue    <= '0;
            r_acc_old  <= '0;
            r_acc_rec  <= '0;
        end else begin
            if (r_state == wms_pkg::ST_SUM) begin
                r_issue  <= r_issue + 1'b1;
                r_rd_rec <= r_issue >= ISS_W'(r_len);
                if (last_old) begin
                    r_slot <= r_rec_slot;
                end else begin
                    r_slot <= (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
                end
            end
            if (r_rd_vld) begin
                if (r_rd_rec) begin
                    r_acc_rec <= r_acc_rec + SUM_W'(i_win_rdata);
                end else begin
                    r_acc_old <= r_acc_old + SUM_W'(i_win_rdata);
                end
            end
        end
        if (r_state == wms_pkg::ST_MUL) begin
            r_prod   <= PROD_W'(r_acc_old) * PROD_W'(i_thr);
            r_rising <= r_acc_rec > r_acc_old;
            r_diff   <= (r_acc_rec > r_acc_old) ? r_acc_rec - r_acc_old
                                                : r_acc_old - r_acc_rec;
            r_nz     <= r_acc_old != '0;
        end
        if (out_load) begin
            r_out.signal_symbol <= r_sym_out;
            r_out.side          <= r_rising ? wms_pkg::SIDE_BUY : wms_pkg::SIDE_SELL;
        end
    end

    assign o_in_stall  = (r_state != wms_pkg::ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

### design/windowed_momentum_signal.sv
// ----------------------------------------------------------------------------
// windowed_momentum_signal
// Per-symbol price ring with moving-sum momentum test against a threshold.
//
//   Port group   Dir  Payload           Handshake
//   i_in_*       in   wms_pkg::t_in     i_in_valid / o_in_stall
//   o_out_*      out  wms_pkg::t_out    o_out_valid / i_out_stall
//   i_cfg_*      in   threshold 24b     i_cfg_we, no wait
//
// A request below the fill level only updates the ring. One that reaches
// it sums the min(AVG_LEN, fill) oldest and as many newest prices, bound
// by the single read port of the window RAM, one price per cycle.
// After reset the state RAM is cleared entry by entry before the first
// request is taken. Out-of-range symbols are dropped.
// A held result stalls the block only when the next result is ready.
// ----------------------------------------------------------------------------
module windowed_momentum_signal #(
    parameter int SYMBOLS    = 16,
    parameter int WINDOW_LEN = 20,
    parameter int MIN_FILL   = 10,
    parameter int AVG_LEN    = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  wms_pkg::t_in              i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output wms_pkg::t_out             o_out_data,
    input  logic                      i_out_stall,
    input  logic                      i_cfg_we,
    input  logic [wms_pkg::THR_W-1:0] i_cfg_wdata
);

    localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int ADDR_W = $clog2(SYMBOLS * WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int META_W = CNT_W + SLOT_W;

    logic [wms_pkg::THR_W-1:0]   r_thr;
    logic                        win_we;
    logic [ADDR_W-1:0]           win_addr;
    logic [wms_pkg::PRICE_W-1:0] win_wdata;
    logic [wms_pkg::PRICE_W-1:0] win_rdata;
    logic                        meta_we;
    logic [SYM_W-1:0]            meta_addr;
    logic [META_W-1:0]           meta_wdata;
    logic [META_W-1:0]           meta_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= wms_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    wms_ram #(
        .DEPTH (SYMBOLS * WINDOW_LEN),
        .WIDTH (wms_pkg::PRICE_W)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_addr  (win_addr),
        .i_wdata (win_wdata),
        .o_rdata (win_rdata)
    );

    wms_ram #(
        .DEPTH (SYMBOLS),
        .WIDTH (META_W)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_addr  (meta_addr),
        .i_wdata (meta_wdata),
        .o_rdata (meta_rdata)
    );

    wms_ctrl #(
        .SYMBOLS    (SYMBOLS),
        .WINDOW_LEN (WINDOW_LEN),
        .MIN_FILL   (MIN_FILL),
        .AVG_LEN    (AVG_LEN)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_thr        (r_thr),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall),
        .o_win_we     (win_we),
        .o_win_addr   (win_addr),
        .o_win_wdata  (win_wdata),
        .i_win_rdata  (win_rdata),
        .o_meta_we    (meta_we),
        .o_meta_addr  (meta_addr),
        .o_meta_wdata (meta_wdata),
        .i_meta_rdata (meta_rdata)
    );

endmodule
